[rtl/calendar_date_time_adder_top_assert.svh]
// Assertion macros for the date-time adder.
`ifndef CALENDAR_DATE_TIME_ADDER_TOP_ASSERT_SVH
`define CALENDAR_DATE_TIME_ADDER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CDTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CDTA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/cdta_pkg.sv]
// ----------------------------------------------------------------------------
// Date-time adder package
// Shared widths, types and calendar functions.
// ----------------------------------------------------------------------------
package cdta_pkg;

    localparam int YEAR_LIMIT = 9999;
    localparam int SECS_PER_DAY = 86400;

    // The month total is biased by this many years so that it is never negative.
    localparam int MONTH_BIAS_YEARS = 342;
    // floor(x / 3) is (x * RECIP_3) >> 13 for every x below 8190.
    localparam int RECIP_3 = 2731;
    // The year is biased by a multiple of 400 before the test for 25.
    localparam int YEAR_BIAS = 20000;
    // floor(x / 25) is (x * RECIP_25) >> 21 for every x below 91180.
    localparam int RECIP_25 = 83887;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LOW  = 2'd1;
    localparam logic [1:0] ST_HIGH = 2'd2;

    typedef struct packed {
        logic load;
        logic time_step;
        logic day_step;
        logic fin;
    } cdta_cmd_t;

    typedef struct packed {
        logic time_done;
        logic day_done;
    } cdta_sts_t;

    // Leap year by the 4/100/400 rule; y is signed.
    function automatic logic is_leap(input logic signed [19:0] y);
        logic [16:0] yp;
        logic [33:0] prod;
        logic [16:0] q;
        logic div25;
        begin
            yp = 17'(y + 20'(YEAR_BIAS));
            prod = {17'd0, yp} * 34'(RECIP_25);
            q = 17'(prod >> 21);
            div25 = (17'(q * 17'd25) == yp);
            is_leap = (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'd0));
        end
    endfunction

    // Days in month m (1..12) of a year whose leap flag is given.
    function automatic logic [4:0] days_of(input logic leap, input logic [3:0] m);
        logic [4:0] r;
        begin
            case (m)
                4'd2: r = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
                default: r = 5'd31;
            endcase
            days_of = r;
        end
    endfunction

endpackage

[rtl/cdta_ctrl.sv]
// ----------------------------------------------------------------------------
// Date-time adder controller
// Sequences loading, time normalization, day stepping and result hand-off.
// ----------------------------------------------------------------------------
module cdta_ctrl import cdta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_free,
    input  cdta_sts_t sts,
    output cdta_cmd_t cmd,
    output logic      busy
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TIME = 2'd1;
    localparam logic [1:0] S_DAY  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_fire;
                if (in_fire) state_next = S_TIME;
            end
            S_TIME:
            begin
                cmd.time_step = 1'b1;
                if (sts.time_done) state_next = S_DAY;
            end
            S_DAY:
            begin
                cmd.day_step = 1'b1;
                if (sts.day_done) state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.fin = out_free;
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule

[rtl/cdta_dp.sv]
// ----------------------------------------------------------------------------
// Date-time adder datapath
// Holds the working sums and applies one normalization step per cycle.
// ----------------------------------------------------------------------------
module cdta_dp import cdta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cdta_cmd_t   cmd,
    input  logic [13:0] start_year,
    input  logic [3:0]  start_month,
    input  logic [4:0]  start_day,
    input  logic [4:0]  start_hour,
    input  logic [5:0]  start_minute,
    input  logic [5:0]  start_second,
    input  logic signed [14:0] off_years,
    input  logic signed [12:0] off_months,
    input  logic signed [16:0] off_days,
    input  logic signed [16:0] off_hours,
    input  logic signed [16:0] off_minutes,
    input  logic signed [16:0] off_seconds,
    output cdta_sts_t   sts,
    output logic        res_valid,
    input  logic        res_take,
    output logic [13:0] res_year,
    output logic [3:0]  res_month,
    output logic [4:0]  res_day,
    output logic [4:0]  res_hour,
    output logic [5:0]  res_minute,
    output logic [5:0]  res_second,
    output logic [1:0]  status
);
    // Seconds sum fits in 29 bits signed; days in 22 bits signed.
    logic signed [28:0] secs_reg, secs_next;
    logic signed [21:0] day_reg, day_next;
    logic signed [19:0] year_reg, year_next;
    logic [3:0] mon_reg, mon_next;
    logic [4:0] hr_reg, hr_next;
    logic [5:0] mi_reg, mi_next, sc_reg, sc_next;
    logic tphase_reg, tphase_next;
    logic valid_reg;

    logic signed [28:0] s_in;
    logic signed [19:0] mt_in, y_in;
    logic leap_cur;
    logic [4:0] dl_cur, dl_prev;
    logic signed [19:0] y_prev;
    logic [3:0] m_prev;

    always_comb
    begin
        s_in = 29'(signed'({1'b0, start_hour}) * 3600) + 29'(signed'({1'b0, start_minute}) * 60)
             + 29'(signed'({1'b0, start_second})) + 29'(off_hours * 3600)
             + 29'(off_minutes * 60) + 29'(off_seconds);
        mt_in = 20'(signed'({1'b0, start_year})) + 20'(off_years);
        y_in = mt_in;
        m_prev = 4'd1;
        y_prev = year_reg - 20'sd1;
        if (mon_reg == 4'd1) m_prev = 4'd12;
        else m_prev = mon_reg - 4'd1;
        // December always has 31 days, so the leap flag of the current year serves both.
        leap_cur = is_leap(year_reg);
        dl_cur = days_of(leap_cur, mon_reg);
        dl_prev = days_of(leap_cur, m_prev);
    end

    // Month total split into years and month by a reciprocal division by 12.
    logic signed [14:0] mtot;
    logic [13:0] mx;
    logic [25:0] mprod;
    logic [9:0] mq;
    logic signed [14:0] qy;
    logic [3:0] rm;
    always_comb
    begin
        mtot = 15'(signed'({1'b0, start_month})) - 15'sd1 + 15'(off_months);
        mx = 14'(mtot + 15'(MONTH_BIAS_YEARS * 12));
        mprod = {14'd0, mx[13:2]} * 26'(RECIP_3);
        mq = 10'(mprod >> 13);
        qy = 15'(signed'({5'd0, mq})) - 15'(MONTH_BIAS_YEARS);
        rm = 4'(mx - 14'({4'd0, mq} * 14'd12)) + 4'd1;
    end

    always_comb
    begin
        secs_next = secs_reg;
        day_next = day_reg;
        year_next = year_reg;
        mon_next = mon_reg;
        hr_next = hr_reg;
        mi_next = mi_reg;
        sc_next = sc_reg;
        tphase_next = tphase_reg;
        sts.time_done = 1'b0;
        sts.day_done = 1'b0;
        if (cmd.load)
        begin
            secs_next = s_in;
            day_next = 22'(signed'({1'b0, start_day})) + 22'(off_days);
            year_next = y_in + 20'(qy);
            mon_next = rm;
            tphase_next = 1'b0;
            hr_next = '0;
            mi_next = '0;
            sc_next = '0;
        end
        else if (cmd.time_step)
        begin
            // Day carry one day per cycle, then hours and minutes by subtraction.
            if (secs_reg < 0)
            begin
                secs_next = secs_reg + 29'(SECS_PER_DAY);
                day_next = day_reg - 22'sd1;
            end
            else if (secs_reg >= 29'(SECS_PER_DAY))
            begin
                secs_next = secs_reg - 29'(SECS_PER_DAY);
                day_next = day_reg + 22'sd1;
            end
            else if (!tphase_reg)
            begin
                if (secs_reg >= 29'sd3600)
                begin
                    secs_next = secs_reg - 29'sd3600;
                    hr_next = hr_reg + 5'd1;
                end
                else tphase_next = 1'b1;
            end
            else
            begin
                if (secs_reg >= 29'sd60)
                begin
                    secs_next = secs_reg - 29'sd60;
                    mi_next = mi_reg + 6'd1;
                end
                else
                begin
                    sc_next = 6'(secs_reg);
                    sts.time_done = 1'b1;
                end
            end
        end
        else if (cmd.day_step)
        begin
            if (day_reg > 22'(signed'({1'b0, dl_cur})))
            begin
                day_next = day_reg - 22'(signed'({1'b0, dl_cur}));
                if (mon_reg == 4'd12)
                begin
                    mon_next = 4'd1;
                    year_next = year_reg + 20'sd1;
                end
                else mon_next = mon_reg + 4'd1;
            end
            else if (day_reg < 22'sd1)
            begin
                day_next = day_reg + 22'(signed'({1'b0, dl_prev}));
                mon_next = m_prev;
                if (mon_reg == 4'd1) year_next = y_prev;
            end
            else sts.day_done = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_reg <= secs_next;
        day_reg <= day_next;
        year_reg <= year_next;
        mon_reg <= mon_next;
        hr_reg <= hr_next;
        mi_reg <= mi_next;
        sc_reg <= sc_next;
        tphase_reg <= tphase_next;
        if (cmd.fin)
        begin
            res_month <= mon_reg;
            res_day <= 5'(day_reg);
            res_hour <= hr_reg;
            res_minute <= mi_reg;
            res_second <= sc_reg;
            if (year_reg < 20'sd1)
            begin
                status <= ST_LOW;
                res_year <= 14'd1;
            end
            else if (year_reg > 20'(YEAR_LIMIT))
            begin
                status <= ST_HIGH;
                res_year <= 14'(YEAR_LIMIT);
            end
            else
            begin
                status <= ST_OK;
                res_year <= 14'(year_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (cmd.fin) valid_reg <= 1'b1;
        else if (res_take) valid_reg <= 1'b0;
    end

    assign res_valid = valid_reg;
endmodule

[rtl/calendar_date_time_adder_top.sv]
// ----------------------------------------------------------------------------
// Gregorian date-time adder
// Adds signed year, month, day, hour, minute and second offsets to a date.
// ----------------------------------------------------------------------------
// One word at a time is processed. After a word is accepted, the block carries
// whole days out of the time of day, counts off the whole hours and then the
// whole minutes left in it, steps the day through each month it crosses, and then
// writes the result. The input is ready again as the result is written. A
// finished result waits in the output register while the next word is loaded; a
// second result waits inside the block and holds off the input until the first
// one is read.
module calendar_date_time_adder_top import cdta_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_year, start_month, start_day, start_hour, start_minute, start_second,
    // off_years, off_months, off_days, off_hours, off_minutes, off_seconds
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_year, res_month, res_day, res_hour, res_minute, res_second, status, pad
    output logic [47:0]  m_axis_tdata
);
    cdta_cmd_t cmd;
    cdta_sts_t sts;
    logic busy, in_fire, res_valid, res_take, out_free;
    logic [13:0] ry;
    logic [3:0] rmo;
    logic [4:0] rd, rh;
    logic [5:0] rmi, rs;
    logic [1:0] rst_code;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign res_take = m_axis_tvalid && m_axis_tready;
    assign out_free = !res_valid || m_axis_tready;
    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata = {6'd0, rst_code, rs, rmi, rh, rd, rmo, ry};

    cdta_ctrl u_ctrl (.clk, .rst_n, .in_fire, .out_free, .sts, .cmd, .busy);

    cdta_dp u_dp (
        .clk, .rst_n, .cmd,
        .start_year(s_axis_tdata[13:0]), .start_month(s_axis_tdata[17:14]),
        .start_day(s_axis_tdata[22:18]), .start_hour(s_axis_tdata[27:23]),
        .start_minute(s_axis_tdata[33:28]), .start_second(s_axis_tdata[39:34]),
        .off_years(s_axis_tdata[54:40]), .off_months(s_axis_tdata[67:55]),
        .off_days(s_axis_tdata[84:68]), .off_hours(s_axis_tdata[101:85]),
        .off_minutes(s_axis_tdata[118:102]), .off_seconds(s_axis_tdata[135:119]),
        .sts, .res_valid, .res_take,
        .res_year(ry), .res_month(rmo), .res_day(rd), .res_hour(rh),
        .res_minute(rmi), .res_second(rs), .status(rst_code)
    );

`include "calendar_date_time_adder_top_assert.svh"
    `CDTA_ASSERT_IMP(a_no_accept_busy, busy, !in_fire)
    `CDTA_ASSERT_NEXT(a_fin_valid, cmd.fin, m_axis_tvalid)
    `CDTA_ASSERT_IMP(a_status_code, m_axis_tvalid, rst_code <= ST_HIGH)
endmodule
